FILE: design/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg
// shared types, codes and constants of the button debounce and hold classifier
// ----------------------------------------------------------------------------
package bdh_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int IN_DATA_W     = 40;
  localparam int OUT_DATA_W    = 72;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 24;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BOOT_WINDOW   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FACTORY_HOLD  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COMMISSION    = 2'd3;

  localparam logic [15:0] BOOT_WINDOW_RST  = 16'd500;
  localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [23:0] FACTORY_HOLD_RST = 24'd10000;
  localparam logic [23:0] COMMISSION_RST   = 24'd3000;

  typedef enum logic [2:0] {
    ST_INITIALIZED = 3'd0,
    ST_NOT_INIT    = 3'd1,
    ST_IDLE        = 3'd2,
    ST_EMITTED     = 3'd3,
    ST_REJECTED    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_FACTORY_ARM = 3'd1,
    EV_FACTORY_REQ = 3'd2,
    EV_COMMISSION  = 3'd3,
    EV_IDENTIFY    = 3'd4
  } event_kind_t;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_INIT   = 1'b1
  } command_t;

  typedef struct packed {
    logic [15:0] boot_window_ms;
    logic [15:0] debounce_ms;
    logic [23:0] factory_hold_ms;
    logic [23:0] commission_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic is_ready;
    logic raw_level;
    logic stable_pressed;
    logic boot_done;
    logic suppress_flag;
    logic armed_flag;
  } flags_t;

  typedef struct packed {
    status_t     status;
    event_kind_t event_kind;
    logic [31:0] event_time_ms;
    logic [31:0] held_for_ms;
    logic        stable_level;
  } result_t;

endpackage

FILE: design/button_debounce_hold_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_classifier
// debounced push button with boot qualification and long-press classification
// ----------------------------------------------------------------------------
// in channel: one word per tick. in_tuser carries the command (initialize or
// update), in_tdata the timestamp, raw level and event-accept flag. out
// channel: one word per input word with status, event kind, event time,
// hold duration and the debounced level. cfg port: plain register writes,
// to be made only while no word is in flight; the block does not enforce it.
// an input word passes the input register, then the result register.
// throughput: one word per cycle while the output is not held back; the tick
// logic is a few subtracts and compares between the input and result
// registers, and the tracking state updates in the cycle the input register moves on.
// reset: both stages empty, tracking state cleared (not initialized) and the
// registers back to their defaults.
// stall: a held result keeps out_tvalid high; the input register still takes
// one more word, after which in_tready drops until out_tready returns.
// ----------------------------------------------------------------------------
module button_debounce_hold_classifier #(
  parameter int TIME_BITS = bdh_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command
  input  logic                           in_tuser,
  // now_ms[31:0], pressed_raw[32], event_accept[33], zero pad
  input  logic [bdh_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // event_kind
  output logic [2:0]                     out_tuser,
  // status[2:0], event_time_ms[34:3], held_for_ms[66:35], stable_level[67], zero pad
  output logic [bdh_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [bdh_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bdh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bdh_pkg::*;

  cfg_t    cfg;
  flags_t  flg_r;
  flags_t  flg_nxt;
  result_t res;

  logic [TIME_BITS-1:0] init_stamp_r;
  logic [TIME_BITS-1:0] init_stamp_nxt;
  logic [TIME_BITS-1:0] rcs_r;
  logic [TIME_BITS-1:0] rcs_nxt;
  logic [TIME_BITS-1:0] press_stamp_r;
  logic [TIME_BITS-1:0] press_stamp_nxt;

  logic        s1_vld_r;
  logic        s1_cmd_r;
  logic [31:0] s1_now_r;
  logic        s1_prs_r;
  logic        s1_acc_r;
  logic        s1_go;
  logic        in_fire;

  logic                  out_vld_r;
  logic [2:0]            out_kind_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign s1_go     = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  bdh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bdh_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg                  (cfg),
    .flg                  (flg_r),
    .init_stamp           (init_stamp_r),
    .raw_change_stamp     (rcs_r),
    .press_stamp          (press_stamp_r),
    .command              (s1_cmd_r),
    .now_ms               (s1_now_r),
    .pressed_raw          (s1_prs_r),
    .event_accept         (s1_acc_r),
    .flg_nxt              (flg_nxt),
    .init_stamp_nxt       (init_stamp_nxt),
    .raw_change_stamp_nxt (rcs_nxt),
    .press_stamp_nxt      (press_stamp_nxt),
    .res                  (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_tuser;
      s1_now_r <= in_tdata[31:0];
      s1_prs_r <= in_tdata[32];
      s1_acc_r <= in_tdata[33];
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_r         <= '0;
      init_stamp_r  <= '0;
      rcs_r         <= '0;
      press_stamp_r <= '0;
    end else if (s1_vld_r && s1_go) begin
      flg_r         <= flg_nxt;
      init_stamp_r  <= init_stamp_nxt;
      rcs_r         <= rcs_nxt;
      press_stamp_r <= press_stamp_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_go) begin
      out_kind_r <= res.event_kind;
      out_data_r <= {4'b0, res.stable_level, res.held_for_ms, res.event_time_ms, res.status};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !s1_vld_r && !out_vld_r)
    else $error("pipeline not empty after reset");

  a_kind_status : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((out_kind_r != EV_NONE) ==
                   (out_data_r[2:0] == ST_EMITTED || out_data_r[2:0] == ST_REJECTED)))
    else $error("event kind and status disagree");

  a_not_init_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r[2:0] == ST_NOT_INIT |-> out_kind_r == EV_NONE && !out_data_r[67])
    else $error("word before initialize carries data");

  a_stage_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_go |=> s1_vld_r && $stable(s1_now_r) && $stable(flg_r))
    else $error("stalled tick lost or state moved");

  a_ready_state : assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_go && s1_cmd_r == CMD_INIT |=> flg_r.is_ready && !flg_r.boot_done)
    else $error("initialize did not restart boot window");

endmodule

FILE: design/bdh_cfg.sv
// ----------------------------------------------------------------------------
// bdh_cfg
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module bdh_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bdh_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bdh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bdh_pkg::cfg_t                  cfg
);
  import bdh_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_BOOT_WINDOW:  cfg_nxt.boot_window_ms     = cfg_wdata[15:0];
        REG_DEBOUNCE:     cfg_nxt.debounce_ms        = cfg_wdata[15:0];
        REG_FACTORY_HOLD: cfg_nxt.factory_hold_ms    = cfg_wdata[23:0];
        REG_COMMISSION:   cfg_nxt.commission_hold_ms = cfg_wdata[23:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_window_ms     <= BOOT_WINDOW_RST;
      cfg_r.debounce_ms        <= DEBOUNCE_RST;
      cfg_r.factory_hold_ms    <= FACTORY_HOLD_RST;
      cfg_r.commission_hold_ms <= COMMISSION_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/bdh_step.sv
// ----------------------------------------------------------------------------
// bdh_step
// next-state and result logic for one word: init, boot window, debounce, hold
// ----------------------------------------------------------------------------
module bdh_step #(
  parameter int TIME_BITS = bdh_pkg::TIME_BITS_DEF
) (
  input  bdh_pkg::cfg_t          cfg,
  input  bdh_pkg::flags_t        flg,
  input  logic [TIME_BITS-1:0]   init_stamp,
  input  logic [TIME_BITS-1:0]   raw_change_stamp,
  input  logic [TIME_BITS-1:0]   press_stamp,
  input  logic                   command,
  input  logic [31:0]            now_ms,
  input  logic                   pressed_raw,
  input  logic                   event_accept,
  output bdh_pkg::flags_t        flg_nxt,
  output logic [TIME_BITS-1:0]   init_stamp_nxt,
  output logic [TIME_BITS-1:0]   raw_change_stamp_nxt,
  output logic [TIME_BITS-1:0]   press_stamp_nxt,
  output bdh_pkg::result_t       res
);
  import bdh_pkg::*;

  localparam int CMP_W = (TIME_BITS > 24) ? TIME_BITS : 24;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] since_init;
  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] held;
  logic [TIME_BITS-1:0] rcs_upd;
  logic                 boot_over;
  logic                 settled;
  logic                 long_hold;
  logic                 commission_hold;

  assign now_t      = TIME_BITS'(now_ms);
  assign since_init = now_t - init_stamp;
  assign held       = now_t - press_stamp;
  assign rcs_upd    = (pressed_raw != flg.raw_level) ? now_t : raw_change_stamp;
  assign since_change = now_t - rcs_upd;

  assign boot_over       = CMP_W'(since_init) >= CMP_W'(cfg.boot_window_ms);
  assign settled         = CMP_W'(since_change) >= CMP_W'(cfg.debounce_ms);
  assign long_hold       = CMP_W'(held) >= CMP_W'(cfg.factory_hold_ms);
  assign commission_hold = CMP_W'(held) >= CMP_W'(cfg.commission_hold_ms);

  always_comb begin
    flg_nxt              = flg;
    init_stamp_nxt       = init_stamp;
    raw_change_stamp_nxt = raw_change_stamp;
    press_stamp_nxt      = press_stamp;
    res.status           = ST_IDLE;
    res.event_kind       = EV_NONE;
    res.event_time_ms    = '0;
    res.held_for_ms      = '0;
    res.stable_level     = 1'b0;

    if (command == CMD_INIT) begin
      flg_nxt.raw_level      = pressed_raw;
      flg_nxt.stable_pressed = pressed_raw;
      flg_nxt.boot_done      = 1'b0;
      flg_nxt.suppress_flag  = pressed_raw;
      flg_nxt.armed_flag     = 1'b0;
      flg_nxt.is_ready       = 1'b1;
      init_stamp_nxt         = now_t;
      raw_change_stamp_nxt   = now_t;
      press_stamp_nxt        = now_t;
      res.status             = ST_INITIALIZED;
    end else if (!flg.is_ready) begin
      res.status = ST_NOT_INIT;
    end else if (!flg.boot_done) begin
      // boot window: follow the raw level only
      flg_nxt.raw_level      = pressed_raw;
      flg_nxt.stable_pressed = pressed_raw;
      flg_nxt.suppress_flag  = pressed_raw;
      raw_change_stamp_nxt   = now_t;
      if (boot_over) begin
        flg_nxt.boot_done = 1'b1;
        press_stamp_nxt   = now_t;
      end
    end else begin
      flg_nxt.raw_level    = pressed_raw;
      raw_change_stamp_nxt = rcs_upd;
      if ((pressed_raw != flg.stable_pressed) && settled) begin
        flg_nxt.stable_pressed = pressed_raw;
        if (pressed_raw) begin
          press_stamp_nxt    = now_t;
          flg_nxt.armed_flag = 1'b0;
        end else if (flg.suppress_flag) begin
          flg_nxt.suppress_flag = 1'b0;
          flg_nxt.armed_flag    = 1'b0;
        end else begin
          // release: classify the press
          res.status        = event_accept ? ST_EMITTED : ST_REJECTED;
          res.event_time_ms = 32'(now_t);
          res.held_for_ms   = 32'(held);
          if (flg.armed_flag) begin
            flg_nxt.armed_flag = 1'b0;
            res.event_kind     = EV_FACTORY_REQ;
          end else if (commission_hold) begin
            res.event_kind = EV_COMMISSION;
          end else begin
            res.event_kind = EV_IDENTIFY;
          end
        end
      end else if (flg.stable_pressed && !flg.suppress_flag && !flg.armed_flag &&
                   long_hold) begin
        flg_nxt.armed_flag = event_accept;
        res.status         = event_accept ? ST_EMITTED : ST_REJECTED;
        res.event_kind     = EV_FACTORY_ARM;
        res.event_time_ms  = 32'(now_t);
        res.held_for_ms    = 32'(held);
      end
    end

    if (command == CMD_INIT || flg.is_ready) begin
      res.stable_level = flg_nxt.stable_pressed;
    end
  end

endmodule
